// ===== src/extended_gcd_mod_inverse_defines.svh =====
// Assertion macros shared by the checker of the extended gcd block.
// Needs clk and rst_n visible where a macro is used.
`ifndef EXTENDED_GCD_MOD_INVERSE_DEFINES_SVH
`define EXTENDED_GCD_MOD_INVERSE_DEFINES_SVH

// Clocked property, disabled while reset is applied
`define EGCD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked property that also holds during reset
`define EGCD_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/egcd_pkg.sv =====
// Package for the extended gcd / modular inverse block.
// Holds controller states, datapath commands and the status struct.
package egcd_pkg;

    localparam int OPND_W = 32;
    localparam int COEF_W = 32;
    localparam int DIV_W  = 31;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SETUP,
        S_RED,
        S_CHECK,
        S_EUC,
        S_STEP,
        S_AQ_GO,
        S_AQ,
        S_NORM_GO,
        S_NORM,
        S_FIN
    } state_t;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_RED_START,
        CMD_RED_DONE,
        CMD_EUC_START,
        CMD_EUC_DONE,
        CMD_STEP_START,
        CMD_STEP_DONE,
        CMD_AQ_START,
        CMD_AQ_DONE,
        CMD_NORM_START,
        CMD_NORM_DONE,
        CMD_FINISH
    } cmd_t;

    typedef struct packed {
        logic mode;
        logic bad;
        logic loop_go;
        logic b_nz;
        logic div_done;
        logic out_valid;
    } dp_status_t;

endpackage

// ===== src/egcd_if.sv =====
// Request and result channel interfaces of the extended gcd block.
// Depends on egcd_pkg for field widths.
interface egcd_in_if;
    import egcd_pkg::*;
    logic                      valid;
    logic                      ready;
    logic                      action;
    logic signed [OPND_W-1:0]  first_operand;
    logic signed [OPND_W-1:0]  second_operand;

    modport source (output valid, output action, output first_operand,
                    output second_operand, input ready);
    modport sink   (input valid, input action, input first_operand,
                    input second_operand, output ready);
endinterface

interface egcd_out_if;
    import egcd_pkg::*;
    logic                      valid;
    logic                      ready;
    logic        [DIV_W-1:0]   divisor;
    logic signed [COEF_W-1:0]  coef_first;
    logic signed [COEF_W-1:0]  coef_second;
    logic        [DIV_W-1:0]   inverse;

    modport source (output valid, output divisor, output coef_first,
                    output coef_second, output inverse, input ready);
    modport sink   (input valid, input divisor, input coef_first,
                    input coef_second, input inverse, output ready);
endinterface

// ===== src/egcd_div.sv =====
// Restoring divider, one quotient bit per cycle, with two multiply
// accumulators that build quotient * multiplicand as the bits arrive.
module egcd_div #(
    parameter int WIDTH = 32
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [WIDTH-1:0]       dividend,
    input  logic [WIDTH-1:0]       divisor,
    input  logic signed [WIDTH+1:0] mult1,
    input  logic signed [WIDTH+1:0] mult2,
    output logic                   done,
    output logic [WIDTH-1:0]       rem,
    output logic signed [WIDTH+1:0] acc1,
    output logic signed [WIDTH+1:0] acc2
);
    localparam int CW   = WIDTH + 2;
    localparam int CNTW = $clog2(WIDTH);

    logic                 busy_reg, done_reg;
    logic [CNTW-1:0]      cnt_reg;
    logic [WIDTH-1:0]     dvd_reg, dvs_reg, rem_reg;
    logic signed [CW-1:0] m1_reg, m2_reg, acc1_reg, acc2_reg;

    logic [WIDTH:0]       shifted, diff;
    logic                 qbit;
    logic [WIDTH-1:0]     rem_next;
    logic signed [CW-1:0] acc1_next, acc2_next;

    // One restoring step
    always_comb
    begin
        shifted   = {rem_reg, dvd_reg[WIDTH-1]};
        diff      = shifted - {1'b0, dvs_reg};
        qbit      = (shifted >= {1'b0, dvs_reg});
        rem_next  = qbit ? diff[WIDTH-1:0] : shifted[WIDTH-1:0];
        acc1_next = (acc1_reg <<< 1) + (qbit ? m1_reg : CW'(0));
        acc2_next = (acc2_reg <<< 1) + (qbit ? m2_reg : CW'(0));
    end

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNTW'(WIDTH - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Operands and partial results
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg  <= dividend;
            dvs_reg  <= divisor;
            rem_reg  <= '0;
            m1_reg   <= mult1;
            m2_reg   <= mult2;
            acc1_reg <= '0;
            acc2_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg  <= {dvd_reg[WIDTH-2:0], 1'b0};
            rem_reg  <= rem_next;
            acc1_reg <= acc1_next;
            acc2_reg <= acc2_next;
        end
    end

    assign done = done_reg;
    assign rem  = rem_reg;
    assign acc1 = acc1_reg;
    assign acc2 = acc2_reg;
endmodule

// ===== src/egcd_ctrl.sv =====
// Controller of the extended gcd block: sequences reduction, Euclid steps,
// normalization and result hand-off. Depends on egcd_pkg.
module egcd_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  egcd_pkg::dp_status_t status,
    output egcd_pkg::cmd_t       cmd
);
    import egcd_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = CMD_NONE;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd        = CMD_LOAD;
                    state_next = S_SETUP;
                end
            end
            S_SETUP:
            begin
                if (status.bad)
                    state_next = S_FIN;
                else if (status.mode)
                begin
                    cmd        = CMD_RED_START;
                    state_next = S_RED;
                end
                else
                    state_next = S_CHECK;
            end
            S_RED:
            begin
                if (status.div_done)
                begin
                    cmd        = CMD_RED_DONE;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (status.loop_go)
                begin
                    cmd        = CMD_EUC_START;
                    state_next = S_EUC;
                end
                else if (status.b_nz)
                begin
                    cmd        = CMD_STEP_START;
                    state_next = S_STEP;
                end
                else
                    state_next = S_FIN;
            end
            S_EUC:
            begin
                if (status.div_done)
                begin
                    cmd        = CMD_EUC_DONE;
                    state_next = S_CHECK;
                end
            end
            S_STEP:
            begin
                if (status.div_done)
                begin
                    cmd        = CMD_STEP_DONE;
                    state_next = S_AQ_GO;
                end
            end
            S_AQ_GO:
            begin
                cmd        = CMD_AQ_START;
                state_next = S_AQ;
            end
            S_AQ:
            begin
                if (status.div_done)
                begin
                    cmd        = CMD_AQ_DONE;
                    state_next = S_NORM_GO;
                end
            end
            S_NORM_GO:
            begin
                cmd        = CMD_NORM_START;
                state_next = S_NORM;
            end
            S_NORM:
            begin
                if (status.div_done)
                begin
                    cmd        = CMD_NORM_DONE;
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (!status.out_valid)
                begin
                    cmd        = CMD_FINISH;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end
endmodule

// ===== src/egcd_dp.sv =====
// Datapath of the extended gcd block: operand magnitudes, remainder pair,
// coefficient registers, shared divider and the result register.
// Depends on egcd_pkg and egcd_div.
module egcd_dp #(
    parameter int WIDTH = 32
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  egcd_pkg::cmd_t                   cmd,
    output egcd_pkg::dp_status_t             status,
    input  logic                             action,
    input  logic signed [egcd_pkg::OPND_W-1:0] first_operand,
    input  logic signed [egcd_pkg::OPND_W-1:0] second_operand,
    input  logic                             out_ready,
    output logic                             out_valid,
    output logic [egcd_pkg::DIV_W-1:0]       divisor,
    output logic signed [egcd_pkg::COEF_W-1:0] coef_first,
    output logic signed [egcd_pkg::COEF_W-1:0] coef_second,
    output logic [egcd_pkg::DIV_W-1:0]       inverse
);
    import egcd_pkg::*;

    localparam int CW = WIDTH + 2;
    localparam int XW = CW + 32;

    // Operand decode
    logic [63:0]          fa64, fb64;
    logic [WIDTH-1:0]     opa, opb, ma_in, mb_in;

    always_comb
    begin
        fa64  = {32'b0, first_operand};
        fb64  = {32'b0, second_operand};
        opa   = fa64[WIDTH-1:0];
        opb   = fb64[WIDTH-1:0];
        ma_in = opa[WIDTH-1] ? (~opa + 1'b1) : opa;
        mb_in = opb[WIDTH-1] ? (~opb + 1'b1) : opb;
    end

    logic                 mode_reg, na_reg, nb_reg, bad_reg;
    logic [WIDTH-1:0]     ma_reg, mb_reg, x_reg, y_reg, step_reg, aq_reg;
    logic signed [CW-1:0] cu_reg, cv_reg, nu_reg, nv_reg;
    logic                 out_valid_reg;
    logic [DIV_W-1:0]     divisor_reg, inverse_reg;
    logic signed [COEF_W-1:0] coef_first_reg, coef_second_reg;

    // Divider hookup
    logic                 div_start, div_done;
    logic [WIDTH-1:0]     div_dvd, div_dvs, div_rem;
    logic signed [CW-1:0] div_m1, div_m2, div_acc1, div_acc2;
    logic                 cu_pos;
    logic signed [CW-1:0] cu_minus1, cu_neg;

    always_comb
    begin
        cu_pos    = !cu_reg[CW-1] && (cu_reg != '0);
        cu_minus1 = cu_reg - CW'(1);
        cu_neg    = -cu_reg;
        div_start = 1'b0;
        div_dvd   = x_reg;
        div_dvs   = y_reg;
        div_m1    = '0;
        div_m2    = '0;
        unique case (cmd)
            CMD_RED_START:
            begin
                div_start = 1'b1;
                div_dvd   = mb_reg;
                div_dvs   = ma_reg;
            end
            CMD_EUC_START:
            begin
                div_start = 1'b1;
                div_m1    = nu_reg;
                div_m2    = nv_reg;
            end
            CMD_STEP_START:
            begin
                div_start = 1'b1;
                div_dvd   = mb_reg;
                div_dvs   = x_reg;
                div_m1    = CW'(1);
            end
            CMD_AQ_START:
            begin
                div_start = 1'b1;
                div_dvd   = ma_reg;
                div_dvs   = x_reg;
                div_m1    = CW'(1);
            end
            CMD_NORM_START:
            begin
                div_start = 1'b1;
                div_dvd   = cu_pos ? cu_minus1[WIDTH-1:0] : cu_neg[WIDTH-1:0];
                div_dvs   = step_reg;
                div_m2    = CW'(aq_reg);
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    egcd_div #(.WIDTH(WIDTH)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dvs),
        .mult1    (div_m1),
        .mult2    (div_m2),
        .done     (div_done),
        .rem      (div_rem),
        .acc1     (div_acc1),
        .acc2     (div_acc2)
    );

    // Result formatting
    logic signed [CW-1:0] u_res, v_res, inv_res;
    logic signed [XW-1:0] u_x, v_x, inv_x, d_x;

    always_comb
    begin
        u_res   = '0;
        v_res   = '0;
        inv_res = '0;
        if (!mode_reg)
        begin
            u_res = (ma_reg == '0) ? '0 : (na_reg ? -cu_reg : cu_reg);
            v_res = (mb_reg == '0) ? '0 : (nb_reg ? -cv_reg : cv_reg);
        end
        else if (!bad_reg)
        begin
            u_res   = cu_reg;
            v_res   = (mb_reg == '0) ? '0 : cv_reg;
            inv_res = (ma_reg == WIDTH'(1)) ? '0 : v_res + CW'(ma_reg);
        end
        u_x   = XW'(u_res);
        v_x   = XW'(v_res);
        inv_x = XW'(inv_res);
        d_x   = bad_reg ? '0 : XW'(x_reg);
    end

    // Operand and coefficient registers
    always_ff @(posedge clk)
    begin
        unique case (cmd)
            CMD_LOAD:
            begin
                mode_reg <= action;
                na_reg   <= opa[WIDTH-1];
                nb_reg   <= opb[WIDTH-1];
                bad_reg  <= action && (opa[WIDTH-1] || (opa == '0));
                ma_reg   <= ma_in;
                mb_reg   <= mb_in;
                x_reg    <= ma_in;
                y_reg    <= mb_in;
                cu_reg   <= CW'(1);
                cv_reg   <= '0;
                nu_reg   <= '0;
                nv_reg   <= CW'(1);
            end
            CMD_RED_DONE:
            begin
                // residue of k in 0..n-1, negative k folded up
                if (nb_reg && (div_rem != '0))
                begin
                    mb_reg <= ma_reg - div_rem;
                    y_reg  <= ma_reg - div_rem;
                end
                else if (nb_reg)
                begin
                    mb_reg <= '0;
                    y_reg  <= '0;
                end
                else
                begin
                    mb_reg <= div_rem;
                    y_reg  <= div_rem;
                end
                x_reg <= ma_reg;
            end
            CMD_EUC_DONE:
            begin
                cu_reg <= nu_reg;
                cv_reg <= nv_reg;
                nu_reg <= cu_reg - div_acc1;
                nv_reg <= cv_reg - div_acc2;
                x_reg  <= y_reg;
                y_reg  <= div_rem;
            end
            CMD_STEP_DONE:
                step_reg <= div_acc1[WIDTH-1:0];
            CMD_AQ_DONE:
                aq_reg <= div_acc1[WIDTH-1:0];
            CMD_NORM_DONE:
            begin
                // bring u into 1..step, move v by the same multiple
                if (cu_pos)
                begin
                    cu_reg <= CW'(div_rem) + CW'(1);
                    cv_reg <= cv_reg + div_acc2;
                end
                else
                begin
                    cu_reg <= CW'(step_reg) - CW'(div_rem);
                    cv_reg <= cv_reg - CW'(aq_reg) - div_acc2;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd == CMD_FINISH)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd == CMD_FINISH)
        begin
            divisor_reg     <= d_x[DIV_W-1:0];
            coef_first_reg  <= u_x[COEF_W-1:0];
            coef_second_reg <= v_x[COEF_W-1:0];
            inverse_reg     <= inv_x[DIV_W-1:0];
        end
    end

    // Status back to the controller
    always_comb
    begin
        status.mode      = mode_reg;
        status.bad       = bad_reg;
        status.loop_go   = (x_reg != y_reg) && (y_reg != '0);
        status.b_nz      = (mb_reg != '0);
        status.div_done  = div_done;
        status.out_valid = out_valid_reg && !out_ready;
    end

    assign out_valid   = out_valid_reg;
    assign divisor     = divisor_reg;
    assign coef_first  = coef_first_reg;
    assign coef_second = coef_second_reg;
    assign inverse     = inverse_reg;
endmodule

// ===== src/extended_gcd_mod_inverse.sv =====
// Top level of the extended gcd / modular inverse block.
// Depends on egcd_pkg, egcd_if, egcd_ctrl, egcd_dp (with egcd_div).
//
//  channel  | dir | fields
//  ---------+-----+---------------------------------------------------
//  in_ch    | in  | action, first_operand, second_operand
//  out_ch   | out | divisor, coef_first, coef_second, inverse
//
// One request at a time; all of its divisions run one after another in the
// shared divider.
// The result register frees the input: the next request is taken while a
// result waits. Reset is asynchronous, active low, and takes effect at once.
module extended_gcd_mod_inverse #(
    parameter int WIDTH = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    egcd_in_if.sink    in_ch,
    egcd_out_if.source out_ch
);
    import egcd_pkg::*;

    cmd_t       cmd;
    dp_status_t status;

    egcd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .status   (status),
        .cmd      (cmd)
    );

    egcd_dp #(.WIDTH(WIDTH)) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .action         (in_ch.action),
        .first_operand  (in_ch.first_operand),
        .second_operand (in_ch.second_operand),
        .out_ready      (out_ch.ready),
        .out_valid      (out_ch.valid),
        .divisor        (out_ch.divisor),
        .coef_first     (out_ch.coef_first),
        .coef_second    (out_ch.coef_second),
        .inverse        (out_ch.inverse)
    );
endmodule

// ===== src/egcd_chk.sv =====
// Port-level checker for the extended gcd block, bound to the top level.
// Depends on extended_gcd_mod_inverse_defines.svh and egcd_pkg.
`include "extended_gcd_mod_inverse_defines.svh"

module egcd_chk (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             in_valid,
    input logic                             in_ready,
    input logic                             out_valid,
    input logic                             out_ready,
    input logic [egcd_pkg::DIV_W-1:0]       divisor,
    input logic signed [egcd_pkg::COEF_W-1:0] coef_first
);
    import egcd_pkg::*;

    // a waiting result is held
    `EGCD_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "result dropped")
    `EGCD_ASSERT(a_out_stable, out_valid && !out_ready |=> $stable(divisor) && $stable(coef_first), "result changed while stalled")
    // one request at a time: taking a request makes the block busy
    `EGCD_ASSERT(a_busy_after_accept, in_valid && in_ready |=> !in_ready, "request taken while busy")
    // a result only appears after the block was busy with a request
    `EGCD_ASSERT(a_result_after_work, $rose(out_valid) |-> $past(!in_ready), "result without work")
endmodule

bind extended_gcd_mod_inverse egcd_chk u_egcd_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .divisor    (out_ch.divisor),
    .coef_first (out_ch.coef_first)
);

// ===== test/tb_top.sv =====
// Testbench for the extended gcd / modular inverse block.
// Predicts each result from the request and checks every result field.
// Depends on egcd_pkg, egcd_if and extended_gcd_mod_inverse.
module tb_top;
    import egcd_pkg::*;

    localparam int OPW = 32;
    localparam int WATCHDOG = 200000;

    typedef struct packed {
        logic [DIV_W-1:0]  divisor;
        logic [COEF_W-1:0] coef_first;
        logic [COEF_W-1:0] coef_second;
        logic [DIV_W-1:0]  inverse;
    } egcd_res_t;

    logic clk;
    logic rst_n;

    egcd_in_if  in_ch ();
    egcd_out_if out_ch ();

    extended_gcd_mod_inverse #(.WIDTH(OPW)) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source)
    );

    egcd_res_t pending_results[$];
    int        mismatches;
    int        idle_cycles;
    bit        calm;
    bit        timed_out;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Extended gcd of magnitudes, coefficient normalized into 1..mb/d
    function automatic logic [63:0] bezout(input logic [63:0] ma, input logic [63:0] mb,
                                           output logic [63:0] cu, output logic [63:0] cv);
        logic [63:0] x, y, nu, nv, q, tu, tv, r, stp, aq, k, m;
        x = ma; y = mb; cu = 1; cv = 0; nu = 0; nv = 1;
        while (x != y && y != 0)
        begin
            q = x / y;
            tu = cu; tv = cv;
            cu = nu; cv = nv;
            nu = tu - q * nu;
            nv = tv - q * nv;
            r = x % y;
            x = y; y = r;
        end
        if (mb != 0)
        begin
            stp = mb / x;
            aq = ma / x;
            if (!cu[63] && cu != 0)
                k = 64'd0 - (cu - 1) / stp;
            else
            begin
                m = 64'd0 - cu;
                k = 1 + m / stp;
            end
            cu += k * stp;
            cv -= k * aq;
        end
        return x;
    endfunction

    // Expected result of one request
    function automatic egcd_res_t predict_egcd(input logic act, input logic [OPW-1:0] fa,
                                               input logic [OPW-1:0] sb);
        logic [63:0] a, b, ma, mb, u, v, d, inv, n, r, t;
        egcd_res_t res;
        a = {{32{fa[31]}}, fa};
        b = {{32{sb[31]}}, sb};
        u = 0; v = 0; d = 0; inv = 0;
        if (!act)
        begin
            ma = a[63] ? 64'd0 - a : a;
            mb = b[63] ? 64'd0 - b : b;
            d = bezout(ma, mb, u, v);
            if (a == 0) u = 0;
            else if (a[63]) u = 64'd0 - u;
            if (b == 0) v = 0;
            else if (b[63]) v = 64'd0 - v;
        end
        else if (!a[63] && a != 0)
        begin
            n = a;
            if (b[63])
            begin
                t = (64'd0 - b) % n;
                r = (t == 0) ? 64'd0 : n - t;
            end
            else
                r = b % n;
            d = bezout(n, r, u, v);
            if (r == 0) v = 0;
            inv = (n == 1) ? 64'd0 : v + n;
        end
        res.divisor = d[30:0];
        res.coef_first = u[31:0];
        res.coef_second = v[31:0];
        res.inverse = inv[30:0];
        return res;
    endfunction

    function automatic bit take_break();
        return !calm && ($urandom_range(99) < 30);
    endfunction

    // Send one request and queue its prediction; valid drops only while idling
    task automatic send_request(input logic act, input logic [OPW-1:0] fa,
                                input logic [OPW-1:0] sb);
        @(negedge clk);
        while (take_break())
        begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.action <= act;
        in_ch.first_operand <= fa;
        in_ch.second_operand <= sb;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        pending_results.insert(pending_results.size(), predict_egcd(act, fa, sb));
    endtask

    function automatic logic [OPW-1:0] rand_operand();
        case ($urandom_range(5))
            0: return $urandom_range(20);
            1: return -$urandom_range(20);
            2: return $urandom_range(5000);
            3: return 32'h8000_0000 | $urandom_range(3);
            default: return $urandom();
        endcase
    endfunction

    task automatic test_directed_gcd();
        send_request(1'b0, 0, 0);
        send_request(1'b0, 0, 7);
        send_request(1'b0, 0, -7);
        send_request(1'b0, 12, 0);
        send_request(1'b0, -12, 0);
        send_request(1'b0, 240, 46);
        send_request(1'b0, -240, 46);
        send_request(1'b0, 240, -46);
        send_request(1'b0, 17, 17);
        send_request(1'b0, 32'h7fff_ffff, 32'h7fff_fffe);
        send_request(1'b0, 32'h8000_0000, 32'h8000_0000);
        send_request(1'b0, 32'h8000_0000, 3);
        send_request(1'b0, 32'h8000_0001, 32'h7fff_ffff);
        send_request(1'b0, 1836311903, 1134903170);
    endtask

    task automatic test_directed_inverse();
        send_request(1'b1, 1, 5);
        send_request(1'b1, 0, 5);
        send_request(1'b1, -7, 3);
        send_request(1'b1, 32'h8000_0000, 3);
        send_request(1'b1, 11, 3);
        send_request(1'b1, 11, -3);
        send_request(1'b1, 11, 22);
        send_request(1'b1, 12, 8);
        send_request(1'b1, 32'h7fff_ffff, 32'h8000_0001);
        send_request(1'b1, 32'h7fff_ffff, 2);
    endtask

    task automatic test_random_mix();
        logic [OPW-1:0] fa;
        for (int i = 0; i < 346; i++)
        begin
            calm = (i >= 150 && i < 210);
            fa = rand_operand();
            if ($urandom_range(1) && $urandom_range(9) != 0)
                send_request(1'b1, $urandom_range(1, 32'h7fff_ffff) >> $urandom_range(30),
                             rand_operand());
            else
                send_request($urandom_range(1), fa, rand_operand());
        end
        calm = 1'b0;
    endtask

    // Result side: random stalls, compare with oldest prediction
    initial
    begin
        egcd_res_t exp_res;
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            out_ch.ready <= !take_break();
            @(posedge clk);
            if (out_ch.valid && out_ch.ready)
            begin
                if (pending_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result divisor=%0d", out_ch.divisor);
                end
                else
                begin
                    exp_res = pending_results.pop_front();
                    if (out_ch.divisor !== exp_res.divisor
                        || out_ch.coef_first !== exp_res.coef_first
                        || out_ch.coef_second !== exp_res.coef_second
                        || out_ch.inverse !== exp_res.inverse)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch exp d=%0d u=%0d v=%0d inv=%0d got d=%0d u=%0d v=%0d inv=%0d",
                                     exp_res.divisor, $signed(exp_res.coef_first),
                                     $signed(exp_res.coef_second), exp_res.inverse,
                                     out_ch.divisor, out_ch.coef_first,
                                     out_ch.coef_second, out_ch.inverse);
                    end
                end
            end
        end
    end

    // Watchdog on cycles without any accepted transfer
    initial
    begin
        idle_cycles = 0;
        timed_out = 1'b0;
        forever
        begin
            @(posedge clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG)
            begin
                timed_out = 1'b1;
                break;
            end
        end
    end

    // Main sequence
    initial
    begin
        mismatches = 0;
        calm = 1'b0;
        rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.action = 1'b0;
        in_ch.first_operand = '0;
        in_ch.second_operand = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        fork
            begin
                test_directed_gcd();
                test_directed_inverse();
                test_random_mix();
                @(negedge clk);
                in_ch.valid <= 1'b0;
                while (pending_results.size() != 0)
                    @(posedge clk);
                repeat (2000) @(posedge clk);
            end
            wait (timed_out);
        join_any
        if (!timed_out && mismatches == 0 && pending_results.size() == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end
endmodule
